// ----- rtl/core/prse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the palette run-list sprite expander.
// No dependencies; every module of the block imports this package.
package prse_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    localparam logic [31:0] SIG_WORD  = 32'h006d6647;
    localparam logic [31:0] TERM_WORD = 32'h2a2a2a2a;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // command kinds passed from the parser to the word emitter
    localparam logic [1:0] K_START = 2'd0;  // signature, size, width/height
    localparam logic [1:0] K_WORD  = 2'd1;  // one byte as a word
    localparam logic [1:0] K_PIX2  = 2'd2;  // two nibble-indexed colours
    localparam logic [1:0] K_PIX1  = 2'd3;  // one byte-indexed colour

    typedef struct packed {
        logic [1:0]  kind;
        logic        term;   // append the terminator word
        logic [31:0] a;      // size word, byte value or pixel byte
        logic [31:0] b;      // width/height word or colour count
    } t_cmd;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] addr;
        logic [31:0]       data;
    } t_pal_wr;

endpackage

// ----- rtl/core/prse_front.sv -----
`timescale 1ns / 1ps
// Stream parser: header, palette loading and line/run/pixel classification.
// Depends on prse_pkg; issues at most one command per byte, and palette writes.
module prse_front import prse_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tvalid,
    input  logic [7:0] i_tdata,
    output logic       o_tready,
    input  logic       i_q_full,
    input  logic       i_q_empty,
    output logic       o_push,
    output t_cmd       o_cmd,
    output t_pal_wr    o_pal_wr
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PALETTE = 3'd1;
    localparam logic [2:0] PH_LINE    = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_LENGTH  = 3'd4;
    localparam logic [2:0] PH_PIXELS  = 3'd5;

    localparam logic [3:0] HDR_CCOUNT = 4'd3;
    localparam logic [3:0] HDR_W_LO   = 4'd8;
    localparam logic [3:0] HDR_W_HI   = 4'd9;
    localparam logic [3:0] HDR_H_LO   = 4'd10;
    localparam logic [3:0] HDR_H_HI   = 4'd11;
    localparam logic [3:0] HDR_S0     = 4'd12;
    localparam logic [3:0] HDR_S1     = 4'd13;
    localparam logic [3:0] HDR_S2     = 4'd14;
    localparam logic [3:0] HDR_LAST   = 4'd15;

    logic [2:0]  r_phase,  n_phase;
    logic [9:0]  r_cnt,    n_cnt;
    logic [7:0]  r_ccount, n_ccount;
    logic [15:0] r_width,  n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_size,   n_size;
    logic [23:0] r_asm,    n_asm;
    logic [15:0] r_lines,  n_lines;
    logic [7:0]  r_runs,   n_runs;
    logic [7:0]  r_pixels, n_pixels;

    logic       accept;
    logic       do_start, do_end_run, do_end_line;
    logic [3:0] pos;
    logic [7:0] entry;

    // palette writes must not race reads of an earlier sprite still queued
    assign o_tready = !i_q_full && ((r_phase != PH_PALETTE) || i_q_empty);
    assign accept   = i_tvalid && o_tready;
    assign pos      = r_cnt[3:0];
    assign entry    = r_cnt[9:2];

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_ccount    = r_ccount;
        n_width     = r_width;
        n_height    = r_height;
        n_size      = r_size;
        n_asm       = r_asm;
        n_lines     = r_lines;
        n_runs      = r_runs;
        n_pixels    = r_pixels;
        do_start    = 1'b0;
        do_end_run  = 1'b0;
        do_end_line = 1'b0;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_pal_wr    = '0;
        if (accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    unique case (pos)
                        HDR_CCOUNT: n_ccount = i_tdata;
                        HDR_W_LO:   n_width  = {8'd0, i_tdata};
                        HDR_W_HI:   n_width  = {i_tdata, r_width[7:0]};
                        HDR_H_LO:   n_height = {8'd0, i_tdata};
                        HDR_H_HI:   n_height = {i_tdata, r_height[7:0]};
                        HDR_S0:     n_size   = {24'd0, i_tdata};
                        HDR_S1:     n_size   = {r_size[31:16], i_tdata, r_size[7:0]};
                        HDR_S2:     n_size   = {r_size[31:24], i_tdata, r_size[15:0]};
                        HDR_LAST:   n_size   = {i_tdata, r_size[23:0]};
                        default:    n_size   = r_size;
                    endcase
                    if (pos == HDR_LAST) begin
                        n_cnt = '0;
                        if (r_ccount == 8'd0) begin
                            do_start = 1'b1;
                        end else begin
                            n_phase = PH_PALETTE;
                        end
                    end else begin
                        n_cnt = {6'd0, pos + 4'd1};
                    end
                end
                PH_PALETTE: begin
                    unique case (r_cnt[1:0])
                        2'd0: n_asm = {16'd0, i_tdata};
                        2'd1: n_asm = {r_asm[23:16], i_tdata, r_asm[7:0]};
                        2'd2: n_asm = {i_tdata, r_asm[15:0]};
                        2'd3: begin
                            o_pal_wr.we   = ({1'b0, entry} < 9'(PAL_DEPTH));
                            o_pal_wr.addr = entry[PAL_AW-1:0];
                            o_pal_wr.data = {i_tdata, r_asm};
                        end
                    endcase
                    n_cnt = r_cnt + 10'd1;
                    if (n_cnt >= {r_ccount, 2'b00}) begin
                        n_cnt    = '0;
                        do_start = 1'b1;
                    end
                end
                PH_LINE: begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_WORD;
                    o_cmd.a    = {24'd0, i_tdata};
                    n_runs     = i_tdata;
                    if (i_tdata == 8'd0) begin
                        do_end_line = 1'b1;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_WORD;
                    o_cmd.a    = {24'd0, i_tdata};
                    n_phase    = PH_LENGTH;
                end
                PH_LENGTH: begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_WORD;
                    o_cmd.a    = {24'd0, i_tdata};
                    n_pixels   = i_tdata;
                    if (i_tdata == 8'd0) begin
                        do_end_run = 1'b1;
                    end else begin
                        n_phase = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    o_push  = 1'b1;
                    o_cmd.a = {24'd0, i_tdata};
                    o_cmd.b = {24'd0, r_ccount};
                    if (r_pixels >= 8'd2) begin
                        o_cmd.kind = K_PIX2;
                        n_pixels   = r_pixels - 8'd2;
                    end else begin
                        o_cmd.kind = K_PIX1;
                        n_pixels   = 8'd0;
                    end
                    do_end_run = (n_pixels == 8'd0);
                end
                default: begin
                    n_phase = PH_HEADER;
                    n_cnt   = '0;
                end
            endcase

            if (do_end_run) begin
                n_runs = r_runs - 8'd1;
                if (n_runs == 8'd0) begin
                    do_end_line = 1'b1;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            if (do_end_line) begin
                n_lines = r_lines - 16'd1;
                if (n_lines == 16'd0) begin
                    o_cmd.term = 1'b1;
                    n_phase    = PH_HEADER;
                    n_cnt      = '0;
                end else begin
                    n_phase = PH_LINE;
                end
            end
            if (do_start) begin
                o_push     = 1'b1;
                o_cmd.kind = K_START;
                o_cmd.a    = n_size;
                o_cmd.b    = {r_width, r_height};
                n_lines    = r_height;
                if (r_height == 16'd0) begin
                    o_cmd.term = 1'b1;
                    n_phase    = PH_HEADER;
                end else begin
                    n_phase = PH_LINE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_cnt    <= '0;
            r_ccount <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_size   <= '0;
            r_asm    <= '0;
            r_lines  <= '0;
            r_runs   <= '0;
            r_pixels <= '0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_ccount <= n_ccount;
            r_width  <= n_width;
            r_height <= n_height;
            r_size   <= n_size;
            r_asm    <= n_asm;
            r_lines  <= n_lines;
            r_runs   <= n_runs;
            r_pixels <= n_pixels;
        end
    end

    // the start command may go out with the last palette write; it reads no colour
    ap_pal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pal_wr.we |-> i_q_empty)
        else $error("palette write while commands pending");
    ap_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_cnt[9:4] == 6'd0))
        else $error("header position out of range");
    ap_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("command pushed into a full queue");

endmodule

// ----- rtl/core/prse_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the parser and the word emitter.
// Depends on prse_pkg for the command type and depth.
module prse_queue import prse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    // present a quiet head while empty
    assign o_head  = o_empty ? '0 : r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/core/prse_back.sv -----
`timescale 1ns / 1ps
// Word emitter: steps through queued commands, reads the colour table,
// drives the output register. Depends on prse_pkg.
module prse_back import prse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_q_valid,
    output logic        o_pop,
    input  t_pal_wr     i_pal_wr,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,
    output logic        o_tlast,
    output logic        o_tuser
);

    logic [31:0] r_pal [PAL_DEPTH];
    logic [31:0] r_rd;

    logic [1:0]  r_step, n_step;
    logic [1:0]  nbody;
    logic        a_last, a_adv, a_use_pal, a_end;
    logic [31:0] a_lit;
    logic [7:0]  a_idx;

    logic        r_b_valid, r_b_use_pal, r_b_inr, r_b_bad, r_b_end;
    logic [31:0] r_b_lit;
    logic        b_adv;
    logic [31:0] b_word;

    logic        r_o_valid, r_o_last, r_o_user;
    logic [31:0] r_o_data;

    always_comb begin
        a_lit     = '0;
        a_use_pal = 1'b0;
        a_idx     = '0;
        unique case (i_head.kind)
            K_START: nbody = 2'd3;
            K_WORD:  nbody = 2'd1;
            K_PIX2:  nbody = 2'd2;
            K_PIX1:  nbody = 2'd1;
        endcase
        a_end  = (r_step == nbody);
        a_last = i_head.term ? a_end : (r_step == nbody - 2'd1);
        if (a_end) begin
            a_lit = TERM_WORD;
        end else begin
            unique case (i_head.kind)
                K_START: a_lit = (r_step == 2'd0) ? SIG_WORD :
                                 (r_step == 2'd1) ? i_head.a : i_head.b;
                K_WORD:  a_lit = i_head.a;
                K_PIX2: begin
                    a_use_pal = 1'b1;
                    a_idx     = (r_step == 2'd0) ? {4'd0, i_head.a[7:4]}
                                                 : {4'd0, i_head.a[3:0]};
                end
                K_PIX1: begin
                    a_use_pal = 1'b1;
                    a_idx     = i_head.a[7:0];
                end
            endcase
        end
    end

    assign b_adv  = r_b_valid && (!r_o_valid || i_tready);
    assign a_adv  = i_q_valid && (!r_b_valid || b_adv);
    assign o_pop  = a_adv && a_last;
    assign n_step = o_pop ? 2'd0 : (a_adv ? r_step + 2'd1 : r_step);
    assign b_word = r_b_use_pal ? (r_b_inr ? r_rd : 32'd0) : r_b_lit;

    always_ff @(posedge i_clk) begin
        if (i_pal_wr.we) begin
            r_pal[i_pal_wr.addr] <= i_pal_wr.data;
        end
        // hold read data while the stage is stalled
        if (a_adv) begin
            r_rd <= r_pal[a_idx[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_lit     <= a_lit;
            r_b_use_pal <= a_use_pal;
            r_b_inr     <= ({1'b0, a_idx} < 9'(PAL_DEPTH));
            r_b_bad     <= a_use_pal && (a_idx >= i_head.b[7:0]);
            r_b_end     <= a_end;
        end
        if (b_adv) begin
            r_o_data <= b_word;
            r_o_last <= r_b_end;
            r_o_user <= r_b_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (a_adv) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_o_valid;
    assign o_tdata  = r_o_data;
    assign o_tlast  = r_o_last;
    assign o_tuser  = r_o_user;

    ap_step_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 2'd0) |-> i_q_valid)
        else $error("command step advanced without a queued command");
    ap_term_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> (r_o_data == TERM_WORD) && !r_o_user)
        else $error("end of sprite on a word other than the terminator");
    // read data matters only on colour words
    ap_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !b_adv) |=> r_b_valid && $stable(r_b_lit)
            && (!r_b_use_pal || $stable(r_rd)))
        else $error("read stage lost its word while stalled");

endmodule

// ----- rtl/core/palette_rle_sprite_expand.sv -----
`timescale 1ns / 1ps
// A byte's command passes the queue, read stage and output register. Throughput:
// one output word per cycle while the receiver is ready; a two-pixel byte gives
// two words, the start command up to four; palette bytes go at one per cycle once
// the queue has drained, as the colour table has one write and one read port.
// Reset: i_rst_n synchronous, active low; clears parser, queue and output valids.
// The colour table is not cleared.
module palette_rle_sprite_expand import prse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] out_word
    output logic        m_axis_tlast,   // end_of_sprite
    output logic        m_axis_tuser    // [0] bad_index
);

    t_cmd    cmd, head;
    t_pal_wr pal_wr;
    logic    push, pop, q_empty, q_full;

    prse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .i_tdata   (s_axis_tdata),
        .o_tready  (s_axis_tready),
        .i_q_full  (q_full),
        .i_q_empty (q_empty),
        .o_push    (push),
        .o_cmd     (cmd),
        .o_pal_wr  (pal_wr)
    );

    prse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    prse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_valid (!q_empty),
        .o_pop     (pop),
        .i_pal_wr  (pal_wr),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast),
        .o_tuser   (m_axis_tuser)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for palette_rle_sprite_expand: feeds sprite byte streams and
// checks every output word against an in-bench expander model. Depends on prse_pkg.
module testbench;
    import prse_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_BYTES  = 150;

    // idle patterns applied per sprite
    localparam int M_BUSY   = 0;  // no idling
    localparam int M_SEND   = 1;  // sender idles 61 of 100
    localparam int M_RECV   = 2;  // receiver stalls 61 of 100
    localparam int M_MIXED  = 3;  // both at 27 of 100

    typedef enum logic [2:0] {
        ST_HEADER, ST_PALETTE, ST_LINE, ST_SKIP, ST_LENGTH, ST_PIXELS
    } t_parse_st;

    typedef struct {
        logic [7:0] b;
        int         pace;
        bit         drain;   // wait for all words out before sending
        bit         hold;    // ask the receiver for a long hold-off
    } t_stream_byte;

    typedef struct {
        logic [31:0] word;
        logic        last;
        logic        bad;
    } t_sprite_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [31:0] out_word
    logic        m_axis_tlast;            // end_of_sprite
    logic        m_axis_tuser;            // [0] bad_index

    palette_rle_sprite_expand uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_stream_byte feed[$];
    t_sprite_word words_due[$];

    int  mismatches = 0;
    int  words_checked = 0;
    int  bad_words = 0;
    int  sprite_ends = 0;
    int  bytes_sent = 0;
    int  sprites_queued = 0;
    int  cycles = 0;
    int  cur_pace = M_BUSY;
    bit  took_beat = 1'b0;
    bit  hold_go = 1'b0;
    int  hold_left = 0;

    // generator bookkeeping
    int  gen_pace = M_BUSY;
    bit  gen_drain = 1'b0;
    bit  gen_hold = 1'b0;
    bit  pal_known [0:255];

    // expander model state
    t_parse_st   x_state = ST_HEADER;
    logic [9:0]  x_pos = '0;
    logic [7:0]  x_colours = '0;
    logic [15:0] x_width = '0;
    logic [15:0] x_height = '0;
    logic [31:0] x_size = '0;
    logic [23:0] x_acc = '0;
    logic [15:0] x_lines = '0;
    logic [7:0]  x_runs = '0;
    logic [7:0]  x_pixels = '0;
    logic [31:0] x_colour_tab [0:PAL_DEPTH-1];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model

    function automatic void owe(logic [31:0] w, logic last, logic bad);
        t_sprite_word sw;
        sw.word = w;
        sw.last = last;
        sw.bad  = bad;
        words_due.push_back(sw);
    endfunction

    function automatic void owe_colour(logic [7:0] ix);
        owe(x_colour_tab[ix], 1'b0, ix >= x_colours);
    endfunction

    function automatic void close_line();
        x_lines = x_lines - 16'd1;
        if (x_lines == 0) begin
            x_state = ST_HEADER;
            x_pos   = '0;
            owe(TERM_WORD, 1'b1, 1'b0);
        end else begin
            x_state = ST_LINE;
        end
    endfunction

    function automatic void close_run();
        x_runs = x_runs - 8'd1;
        if (x_runs == 0)
            close_line();
        else
            x_state = ST_SKIP;
    endfunction

    function automatic void open_lines();
        owe(SIG_WORD, 1'b0, 1'b0);
        owe(x_size, 1'b0, 1'b0);
        owe({x_width, x_height}, 1'b0, 1'b0);
        x_lines = x_height;
        if (x_lines == 0) begin
            x_state = ST_HEADER;
            x_pos   = '0;
            owe(TERM_WORD, 1'b1, 1'b0);
        end else begin
            x_state = ST_LINE;
        end
    endfunction

    function automatic void expand_byte(logic [7:0] b);
        logic [3:0] hpos;
        logic [1:0] lane;
        hpos = x_pos[3:0];
        lane = x_pos[1:0];
        case (x_state)
            ST_HEADER: begin
                case (hpos)
                    4'd3:  x_colours = b;
                    4'd8:  x_width[7:0] = b;
                    4'd9:  x_width[15:8] = b;
                    4'd10: x_height[7:0] = b;
                    4'd11: x_height[15:8] = b;
                    4'd12: x_size = {24'h0, b};
                    4'd13: x_size[15:8] = b;
                    4'd14: x_size[23:16] = b;
                    4'd15: x_size[31:24] = b;
                    default: ;
                endcase
                if (hpos == 4'd15) begin
                    x_pos = '0;
                    if (x_colours == 0)
                        open_lines();
                    else
                        x_state = ST_PALETTE;
                end else begin
                    x_pos = {6'd0, hpos} + 10'd1;
                end
            end
            ST_PALETTE: begin
                if (lane == 2'd3) begin
                    x_colour_tab[x_pos[9:2]] = {b, x_acc};
                end else begin
                    if (lane == 2'd0)
                        x_acc = '0;
                    x_acc[8*lane +: 8] = b;
                end
                x_pos = x_pos + 10'd1;
                if (int'(x_pos) >= 4 * int'(x_colours)) begin
                    x_pos = '0;
                    open_lines();
                end
            end
            ST_LINE: begin
                owe({24'h0, b}, 1'b0, 1'b0);
                x_runs = b;
                if (b == 0)
                    close_line();
                else
                    x_state = ST_SKIP;
            end
            ST_SKIP: begin
                owe({24'h0, b}, 1'b0, 1'b0);
                x_state = ST_LENGTH;
            end
            ST_LENGTH: begin
                owe({24'h0, b}, 1'b0, 1'b0);
                x_pixels = b;
                if (b == 0)
                    close_run();
                else
                    x_state = ST_PIXELS;
            end
            ST_PIXELS: begin
                if (x_pixels >= 8'd2) begin
                    owe_colour({4'h0, b[7:4]});
                    owe_colour({4'h0, b[3:0]});
                    x_pixels = x_pixels - 8'd2;
                end else begin
                    owe_colour(b);
                    x_pixels = '0;
                end
                if (x_pixels == 0)
                    close_run();
            end
            default: begin
                x_state = ST_HEADER;
                x_pos   = '0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic put_byte(input logic [7:0] b);
        t_stream_byte sb;
        sb.b     = b;
        sb.pace  = gen_pace;
        sb.drain = gen_drain;
        sb.hold  = gen_hold;
        feed.push_back(sb);
        gen_drain = 1'b0;
        gen_hold  = 1'b0;
    endtask

    task automatic queue_header(input int n_col, input logic [15:0] w, input logic [15:0] h,
                                input logic [31:0] size);
        logic [31:0] colour;
        repeat (3) put_byte(8'($urandom_range(0, 255)));
        put_byte(8'(n_col));
        repeat (4) put_byte(8'($urandom_range(0, 255)));
        put_byte(w[7:0]);
        put_byte(w[15:8]);
        put_byte(h[7:0]);
        put_byte(h[15:8]);
        for (int i = 0; i < 4; i++)
            put_byte(size[8*i +: 8]);
        for (int e = 0; e < n_col; e++) begin
            colour = $urandom;
            for (int i = 0; i < 4; i++)
                put_byte(colour[8*i +: 8]);
            pal_known[e] = 1'b1;
        end
        sprites_queued++;
    endtask

    // odd_ix < 0 picks a random stored entry for an odd final pixel
    task automatic queue_run(input logic [7:0] skip, input logic [7:0] len, input int odd_ix);
        logic [7:0] b;
        int left;
        put_byte(skip);
        put_byte(len);
        left = len;
        while (left >= 2) begin
            put_byte(8'($urandom_range(0, 255)));
            left -= 2;
        end
        if (left == 1) begin
            if (odd_ix >= 0) begin
                b = 8'(odd_ix);
            end else begin
                do b = 8'($urandom_range(0, 255)); while (!pal_known[b]);
            end
            put_byte(b);
        end
    endtask

    task automatic queue_line(input int runs, input int max_len);
        put_byte(8'(runs));
        repeat (runs) queue_run(8'($urandom_range(0, 255)), 8'($urandom_range(0, max_len)), -1);
    endtask

    task automatic queue_sprite(input int n_col, input int h, input int max_runs,
                                input int max_len, input bit hold_body);
        queue_header(n_col, 16'($urandom_range(0, 65535)), 16'(h), $urandom);
        gen_hold = hold_body;
        repeat (h) queue_line($urandom_range(0, max_runs), max_len);
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge i_clk) begin : drive
        t_stream_byte it;
        bit idle;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            hold_go       <= 1'b0;
        end else if (s_axis_tvalid && !took_beat) begin
            hold_go <= 1'b0;
        end else if (feed.size() == 0) begin
            s_axis_tvalid <= 1'b0;
            hold_go       <= 1'b0;
        end else begin
            it = feed[0];
            idle = (it.drain && words_due.size() != 0)
                || (it.pace == M_SEND  && $urandom_range(0, 99) < 61)
                || (it.pace == M_MIXED && $urandom_range(0, 99) < 27);
            if (idle) begin
                s_axis_tvalid <= 1'b0;
                hold_go       <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.b;
                cur_pace      <= it.pace;
                hold_go       <= it.hold;
                void'(feed.pop_front());
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_go) begin
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (cur_pace == M_RECV) begin
            m_axis_tready <= $urandom_range(0, 99) >= 61;
        end else if (cur_pace == M_MIXED) begin
            m_axis_tready <= $urandom_range(0, 99) >= 27;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin : watch
        t_sprite_word exp_w;
        if (!i_rst_n) begin
            took_beat <= 1'b0;
        end else begin
            // check output first: any word leaving now belongs to an older byte
            if (m_axis_tvalid && m_axis_tready) begin
                if (words_due.size() == 0) begin
                    $error("unexpected word %h (last %b, bad %b)",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    mismatches++;
                end else begin
                    exp_w = words_due.pop_front();
                    words_checked++;
                    if (m_axis_tlast)
                        sprite_ends++;
                    if (m_axis_tuser)
                        bad_words++;
                    if (m_axis_tdata !== exp_w.word) begin
                        $error("out_word: expected %h, got %h", exp_w.word, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== exp_w.last) begin
                        $error("end_of_sprite: expected %b, got %b", exp_w.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tuser !== exp_w.bad) begin
                        $error("bad_index: expected %b, got %b", exp_w.bad, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            took_beat <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                expand_byte(s_axis_tdata);
                bytes_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, words_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int rand_start;
        int k;
        for (int i = 0; i < 256; i++)
            pal_known[i] = 1'b0;

        // zero colours, zero height: terminator right behind the header words
        gen_pace  = M_BUSY;
        gen_drain = 1'b1;
        queue_header(0, 16'hffff, 16'd0, 32'hffffffff);

        // zero colours, a line with no runs and a run of zero length
        gen_pace = M_RECV;
        queue_header(0, 16'd0, 16'd2, 32'd0);
        put_byte(8'd0);
        put_byte(8'd1);
        put_byte(8'd255);
        put_byte(8'd0);

        // sixteen colours, widest run, odd pixels at both ends of the palette
        gen_pace  = M_MIXED;
        gen_drain = 1'b1;
        queue_header(16, 16'h8000, 16'd3, 32'h0001_2345);
        put_byte(8'd2);
        queue_run(8'd0, 8'd1, 0);
        queue_run(8'd255, 8'd3, 15);
        gen_hold = 1'b1;
        put_byte(8'd1);
        queue_run(8'd7, 8'd255, 9);
        put_byte(8'd3);
        queue_run(8'd1, 8'd2, -1);
        queue_run(8'd2, 8'd16, -1);
        queue_run(8'd3, 8'd5, 15);

        // three colours: indices past the count read older entries, flagged bad
        gen_pace  = M_SEND;
        gen_drain = 1'b1;
        queue_header(3, 16'd9, 16'd2, 32'h0000_0100);
        put_byte(8'd1);
        put_byte(8'd0);
        put_byte(8'd9);
        put_byte(8'h01);
        put_byte(8'h23);
        put_byte(8'hf4);
        put_byte(8'hcd);
        put_byte(8'd14);
        put_byte(8'd0);

        // random sprites, idle pattern changing with each sprite
        rand_start = feed.size();
        k = 0;
        while (feed.size() - rand_start < RAND_BYTES) begin
            gen_pace  = k % 4;
            gen_drain = (k % 5 == 0);
            queue_sprite(($urandom_range(0, 4) == 0) ? $urandom_range(21, 40)
                                                     : $urandom_range(0, 20),
                         ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
                         3,
                         ($urandom_range(0, 9) < 7) ? 12 : 60,
                         1'b0);
            k++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed.size() != 0 || s_axis_tvalid || words_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("ran %0d sprites, %0d stream bytes, %0d words checked",
                 sprites_queued, bytes_sent, words_checked);
        $display("%0d words flagged bad index, %0d sprite ends seen", bad_words, sprite_ends);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/prse_pkg.sv
rtl/core/prse_front.sv
rtl/core/prse_queue.sv
rtl/core/prse_back.sv
rtl/core/palette_rle_sprite_expand.sv
sim/testbench.sv
